>>> design/dhlb_pkg.sv
// Shared types for the degree histogram block: payload structs, controller
// states, and the command/status bundles between controller and datapath.
// No dependencies.
package dhlb_pkg;

    localparam int DEG_W = 10;
    localparam int VTX_W = 20;
    localparam int TOT_W = 21;

    typedef struct packed {
        logic [DEG_W-1:0] out_count;
        logic [DEG_W-1:0] in_count;
        logic             final_vertex;
    } t_dh_in;

    typedef struct packed {
        logic [DEG_W-1:0] peak_degree;
        logic [VTX_W-1:0] peak_vertex;
        logic [DEG_W-1:0] bin_start;
        logic [TOT_W-1:0] bin_total;
        logic             clipped;
        logic             final_bin;
    } t_dh_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_DRAIN,
        ST_SWEEP,
        ST_FETCH,
        ST_EMIT
    } t_dh_state;

    typedef struct packed {
        logic take_in;
        logic wipe;
        logic start_sweep;
        logic sweep_rd;
        logic emit;
        logic run_clear;
    } t_dh_cmd;

    typedef struct packed {
        logic wipe_last;
        logic in_final;
        logic bin_end;
        logic sweep_done;
        logic out_free;
    } t_dh_sts;

endpackage

>>> design/dhlb_ctrl.sv
// Controller for the degree histogram: sequences the post-reset wipe, the
// load phase, and the per-bin readout sweep. Depends on dhlb_pkg.
module dhlb_ctrl
    import dhlb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dh_sts i_sts,
    output t_dh_cmd o_cmd
);

    t_dh_state r_state;
    t_dh_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.wipe_last) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.in_final) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (i_sts.bin_end) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.sweep_done ? ST_LOAD : ST_SWEEP;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR: o_cmd.wipe        = 1'b1;
            ST_LOAD:  o_cmd.take_in     = 1'b1;
            ST_DRAIN: o_cmd.start_sweep = 1'b1;
            ST_SWEEP: o_cmd.sweep_rd    = 1'b1;
            ST_FETCH: o_cmd             = '0;
            ST_EMIT: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.run_clear = i_sts.out_free && i_sts.sweep_done;
            end
            default:  o_cmd             = '0;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.take_in, o_cmd.wipe, o_cmd.start_sweep, o_cmd.sweep_rd, o_cmd.emit}))
        else $error("controller issued overlapping commands");

    a_drain_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_in && i_sts.in_final) |=> o_cmd.start_sweep)
        else $error("final vertex not followed by drain");

    a_fetch_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.sweep_rd && i_sts.bin_end) |=> ##1 (r_state == ST_EMIT))
        else $error("bin end did not lead to emit");

endmodule

>>> design/dhlb_datapath.sv
// Datapath for the degree histogram: degree compute and clip, histogram
// memory with read-modify-write forwarding, peak tracking, bin accumulator
// and output register. Depends on dhlb_pkg.
module dhlb_datapath
    import dhlb_pkg::*;
#(
    parameter int DEGREE_BINS  = 1024,
    parameter int MAX_VERTICES = 1048576
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dh_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dh_out o_out_data,
    input  t_dh_cmd i_cmd,
    output t_dh_sts o_sts
);

    localparam int AW = $clog2(DEGREE_BINS);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [16:0]   TOP_DEG = 17'(DEGREE_BINS - 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

    logic [TOT_W-1:0] mem [DEGREE_BINS];

    logic             r_sum;
    logic [AW-1:0]    r_max;
    logic [VTX_W-1:0] r_idx;
    logic [CW-1:0]    r_cnt;
    logic             r_clip;

    logic             r_a_vld;
    logic [AW-1:0]    r_a_addr;
    logic [TOT_W-1:0] r_rd_data;
    logic             r_fwd;
    logic [TOT_W-1:0] r_fwd_data;

    logic [AW-1:0]    r_wipe_addr;
    logic [AW-1:0]    r_sw_addr;
    logic [AW-1:0]    r_lo;
    logic             r_sw_vld;
    logic             r_sw_last;
    logic [TOT_W-1:0] r_acc;

    logic             r_out_vld;
    t_dh_out          r_out;

    logic             accept;
    logic [10:0]      raw_deg;
    logic             over;
    logic [AW-1:0]    deg;
    logic             count_ok;
    logic [AW-1:0]    last_addr;
    logic [AW:0]      sw_next;
    logic             out_free;
    logic [TOT_W-1:0] base;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [TOT_W-1:0] wr_data;

    assign accept   = i_in_valid && i_cmd.take_in;
    assign raw_deg  = r_sum ? ({1'b0, i_in_data.out_count} + {1'b0, i_in_data.in_count})
                            : {1'b0, i_in_data.out_count};
    assign over     = {6'd0, raw_deg} > TOP_DEG;
    assign deg      = over ? AW'(TOP_DEG) : AW'(raw_deg);
    assign count_ok = r_cnt < MAX_CNT;

    assign last_addr = (r_max == '0) ? AW'(1) : r_max;
    assign sw_next   = {1'b0, r_sw_addr} + 1'b1;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign base      = r_fwd ? r_fwd_data : r_rd_data;

    always_comb begin
        rd_addr = i_cmd.sweep_rd ? r_sw_addr : deg;
        wr_en   = 1'b0;
        wr_addr = r_a_addr;
        wr_data = base + 1'b1;
        priority if (i_cmd.wipe) begin
            wr_en   = 1'b1;
            wr_addr = r_wipe_addr;
            wr_data = '0;
        end else if (i_cmd.sweep_rd) begin
            wr_en   = 1'b1;
            wr_addr = r_sw_addr;
            wr_data = '0;
        end else if (r_a_vld) begin
            wr_en   = 1'b1;
        end else begin
            wr_en   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data  <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_fwd      <= wr_en && (wr_addr == rd_addr);
        r_fwd_data <= wr_data;
        r_a_addr   <= deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 1'b1;
            r_max       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_clip      <= 1'b0;
            r_a_vld     <= 1'b0;
            r_wipe_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sum <= i_cfg_wdata;
            end
            if (i_cmd.wipe) begin
                r_wipe_addr <= r_wipe_addr + 1'b1;
            end
            r_a_vld <= accept && count_ok;
            if (i_cmd.run_clear) begin
                r_max  <= '0;
                r_idx  <= '0;
                r_cnt  <= '0;
                r_clip <= 1'b0;
            end else if (accept) begin
                r_clip <= r_clip || over || !count_ok;
                if (count_ok) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (deg > r_max) begin
                        r_max <= deg;
                        r_idx <= VTX_W'(r_cnt);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_sw_vld <= i_cmd.sweep_rd;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_sweep) begin
            r_sw_addr <= '0;
            r_lo      <= '0;
            r_acc     <= '0;
        end else begin
            if (i_cmd.sweep_rd) begin
                r_sw_addr <= AW'(sw_next);
                r_sw_last <= r_sw_addr == last_addr;
            end
            if (i_cmd.emit) begin
                r_lo  <= r_sw_addr;
                r_acc <= '0;
            end else if (r_sw_vld) begin
                r_acc <= r_acc + r_rd_data;
            end
        end
        if (i_cmd.emit) begin
            r_out.peak_degree <= DEG_W'(r_max);
            r_out.peak_vertex <= r_idx;
            r_out.bin_start   <= DEG_W'(r_lo);
            r_out.bin_total   <= r_acc;
            r_out.clipped     <= r_clip;
            r_out.final_bin   <= r_sw_last;
        end
    end

    assign o_in_stall  = !i_cmd.take_in;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign o_sts.wipe_last  = r_wipe_addr == AW'(DEGREE_BINS - 1);
    assign o_sts.in_final   = accept && i_in_data.final_vertex;
    assign o_sts.bin_end    = ((sw_next & {1'b0, r_sw_addr}) == '0) || (r_sw_addr == last_addr);
    assign o_sts.sweep_done = r_sw_last;
    assign o_sts.out_free   = out_free;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded over a stalled output");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep_rd |-> (r_sw_addr <= last_addr))
        else $error("sweep ran past the peak degree");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("vertex count beyond limit");

    a_peak_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cmd.run_clear)) |-> (r_max >= $past(r_max)))
        else $error("peak degree fell within a run");

endmodule

>>> design/degree_histogram_log_bins.sv
// Degree histogram with power-of-two bins: top level.
// Joins dhlb_ctrl and dhlb_datapath; depends on dhlb_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one vertex per
//   transfer with its out- and in-degree. While loading, one vertex is taken
//   every cycle; the histogram read-modify-write forwards its own result.
//   The transfer marked final_vertex starts readout: input stalls, and one
//   result per bin (0, 1, [2,4), [4,8), ...) leaves on the output channel
//   (o_out_valid / i_out_stall / o_out_data). Readout reads one histogram
//   entry per cycle up to the peak degree, passing through a fetch and an
//   emit state per bin, and waits on any output stall. Entries are cleared
//   as they are read, so the next graph loads right after the last bin is
//   registered. i_out_stall holds the output register and pauses readout;
//   nothing is dropped. After reset the histogram memory is wiped, one entry
//   per cycle, with the input stalled. i_cfg_we writes the mode bit (1 = out
//   plus in, 0 = out only, reset 1); the user must write it only while the
//   block is idle, which the block itself does not enforce.
module degree_histogram_log_bins
    import dhlb_pkg::*;
#(
    parameter int DEGREE_BINS  = 1024,
    parameter int MAX_VERTICES = 1048576
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dh_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dh_out o_out_data
);

    t_dh_cmd cmd;
    t_dh_sts sts;

    dhlb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dhlb_datapath #(
        .DEGREE_BINS  (DEGREE_BINS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> tb/degree_histogram_log_bins_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for degree_histogram_log_bins: a directed table,
// then random graphs, each checked against a predictor.
// Depends on dhlb_pkg and the degree_histogram_log_bins RTL.
module degree_histogram_log_bins_test;
    import dhlb_pkg::*;

    localparam int DEGREE_BINS    = 1024;
    localparam int MAX_VERTICES   = 1048576;
    localparam int RANDOM_ITEMS   = 110;
    localparam int CALM_ITEMS     = 30;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        bit              sum_mode;
        bit [DEG_W-1:0]  out_count;
        bit [DEG_W-1:0]  in_count;
        bit              fin;
        bit              pinned;
        bit [3:0]        bin_count;
        bit [DEG_W-1:0]  peak;
        bit              clip;
    } t_plan_row;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_we = 1'b0;
    logic    cfg_wdata = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    t_dh_in  in_data = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_dh_out out_data;

    logic [TOT_W-1:0] degree_count [DEGREE_BINS];
    logic [DEG_W-1:0] peak_degree;
    logic [VTX_W-1:0] peak_vertex;
    logic [TOT_W-1:0] vertices_taken;
    logic             saturated;
    logic             add_in_degree = 1'b1;
    t_dh_out          bins_due [$];
    t_plan_row        plan [$];
    int               errors = 0;
    int               quiet_cycles = 0;
    bit               quiet_tail = 1'b0;

    degree_histogram_log_bins dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic clear_histogram();
        for (int d = 0; d < DEGREE_BINS; d++) begin
            degree_count[d] = '0;
        end
        peak_degree    = '0;
        peak_vertex    = '0;
        vertices_taken = '0;
        saturated      = 1'b0;
    endtask

    task automatic tally_vertex(input t_dh_in v, output int unsigned n_bins,
                                output t_dh_out last_bin);
        int unsigned      degree;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      d;
        logic [TOT_W-1:0] total;
        t_dh_out          bin;
        n_bins   = 0;
        last_bin = '0;
        degree = add_in_degree ? int'(v.out_count) + int'(v.in_count) : int'(v.out_count);
        if (degree > DEGREE_BINS - 1) begin
            degree    = DEGREE_BINS - 1;
            saturated = 1'b1;
        end
        if (vertices_taken < MAX_VERTICES) begin
            degree_count[degree] = degree_count[degree] + 1'b1;
            if (degree > peak_degree) begin
                peak_degree = DEG_W'(degree);
                peak_vertex = vertices_taken[VTX_W-1:0];
            end
            vertices_taken = vertices_taken + 1'b1;
        end else begin
            saturated = 1'b1;
        end
        if (v.final_vertex) begin
            lo = 0;
            while (lo < 2 || (lo <= peak_degree && lo < DEGREE_BINS)) begin
                hi    = (lo < 2) ? lo + 1 : lo * 2;
                total = '0;
                for (d = lo; d < hi && d < DEGREE_BINS; d++) begin
                    total = total + degree_count[d];
                end
                bin.peak_degree = peak_degree;
                bin.peak_vertex = peak_vertex;
                bin.bin_start   = lo[DEG_W-1:0];
                bin.bin_total   = total;
                bin.clipped     = saturated;
                lo = hi;
                bin.final_bin   = !(lo < 2 || (lo <= peak_degree && lo < DEGREE_BINS));
                bins_due.push_back(bin);
                n_bins++;
                last_bin = bin;
            end
            clear_histogram();
        end
    endtask

    task automatic send_vertex(input t_dh_in v, input bit may_pause,
                               output int unsigned n_bins, output t_dh_out last_bin);
        if (may_pause && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        tally_vertex(v, n_bins, last_bin);
    endtask

    task automatic wait_drained();
        while (bins_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic sum_mode);
        in_valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= sum_mode;
        @(posedge clk);
        cfg_we        <= 1'b0;
        add_in_degree = sum_mode;
    endtask

    task automatic add_row(input bit sum_mode, input int oc, input int ic, input bit fin,
                           input bit pinned, input int bin_count, input int peak,
                           input bit clip);
        t_plan_row r;
        r.sum_mode  = sum_mode;
        r.out_count = oc[DEG_W-1:0];
        r.in_count  = ic[DEG_W-1:0];
        r.fin       = fin;
        r.pinned    = pinned;
        r.bin_count = bin_count[3:0];
        r.peak      = peak[DEG_W-1:0];
        r.clip      = clip;
        plan.push_back(r);
    endtask

    function automatic logic [DEG_W-1:0] pick_count(input bit wide);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return wide ? '1 : DEG_W'(1);
            default: return wide ? DEG_W'($urandom_range(0, 1023)) : DEG_W'($urandom_range(0, 9));
        endcase
    endfunction

    always @(posedge clk) begin
        t_dh_out want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (bins_due.size() == 0) begin
                report_mismatch("bin result with nothing pending", out_data.bin_start, 0);
            end else begin
                want = bins_due.pop_front();
                if (out_data.peak_degree !== want.peak_degree)
                    report_mismatch("peak_degree", out_data.peak_degree, want.peak_degree);
                if (out_data.peak_vertex !== want.peak_vertex)
                    report_mismatch("peak_vertex", out_data.peak_vertex, want.peak_vertex);
                if (out_data.bin_start !== want.bin_start)
                    report_mismatch("bin_start", out_data.bin_start, want.bin_start);
                if (out_data.bin_total !== want.bin_total)
                    report_mismatch("bin_total", out_data.bin_total, want.bin_total);
                if (out_data.clipped !== want.clipped)
                    report_mismatch("clipped", out_data.clipped, want.clipped);
                if (out_data.final_bin !== want.final_bin)
                    report_mismatch("final_bin", out_data.final_bin, want.final_bin);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 63) == 0) begin
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
        end
    end

    initial begin
        t_dh_in      v;
        t_plan_row   r;
        t_dh_out     last_bin;
        int unsigned n_bins;
        int unsigned sent;
        int unsigned len;
        bit          wide;

        clear_histogram();

        add_row(1, 0, 0, 1, 1, 2, 0, 0);
        add_row(1, 1023, 1023, 1, 1, 11, 1023, 1);
        add_row(1, 1, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 1, 0, 0, 0, 0, 0);
        add_row(1, 2, 2, 0, 0, 0, 0, 0);
        add_row(1, 3, 1, 1, 1, 4, 4, 0);
        add_row(1, 512, 511, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 1, 1, 11, 1023, 0);
        add_row(0, 1023, 1023, 1, 1, 11, 1023, 0);
        add_row(0, 5, 1023, 0, 0, 0, 0, 0);
        add_row(0, 0, 1023, 0, 0, 0, 0, 0);
        add_row(0, 8, 0, 1, 1, 5, 8, 0);
        add_row(0, 682, 341, 0, 0, 0, 0, 0);
        add_row(0, 341, 682, 1, 0, 0, 0, 0);
        add_row(1, 1023, 1, 0, 0, 0, 0, 0);
        add_row(1, 600, 700, 0, 0, 0, 0, 0);
        add_row(1, 1, 1022, 1, 1, 11, 1023, 1);
        add_row(1, 2, 0, 0, 0, 0, 0, 0);
        add_row(1, 3, 0, 0, 0, 0, 0, 0);
        add_row(1, 7, 0, 0, 0, 0, 0, 0);
        add_row(1, 8, 0, 1, 0, 0, 0, 0);
        add_row(1, 511, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 512, 1, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            r = plan[i];
            if (r.sum_mode != add_in_degree) set_mode(r.sum_mode);
            v.out_count    = r.out_count;
            v.in_count     = r.in_count;
            v.final_vertex = r.fin;
            send_vertex(v, 1'b1, n_bins, last_bin);
            if (r.pinned) begin
                if (n_bins != r.bin_count) report_mismatch("bin count", n_bins, r.bin_count);
                if (last_bin.peak_degree != r.peak)
                    report_mismatch("predicted peak", last_bin.peak_degree, r.peak);
                if (last_bin.clipped != r.clip)
                    report_mismatch("predicted clip", last_bin.clipped, r.clip);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) set_mode(1'($urandom_range(0, 1)));
            len  = $urandom_range(1, 12);
            wide = ($urandom_range(0, 4) == 0);
            for (int unsigned k = 0; k < len; k++) begin
                v.out_count    = pick_count(wide);
                v.in_count     = pick_count(wide);
                v.final_vertex = (k == len - 1);
                send_vertex(v, !quiet_tail, n_bins, last_bin);
                sent++;
            end
            if (sent + CALM_ITEMS >= RANDOM_ITEMS) quiet_tail = 1'b1;
        end
        in_valid <= 1'b0;

        wait_drained();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
